### src/mrs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modbus RTU slave responder package
// Function codes, sizing defaults, CRC-16 step and the sequencer microprogram.
// ----------------------------------------------------------------------------
package mrs_pkg;

  localparam int NumCoilsDef = 16;
  localparam int NumRegsDef  = 16;

  localparam logic [7:0]  FUNC_READ_COILS = 8'd1;
  localparam logic [7:0]  FUNC_READ_REGS  = 8'd3;
  localparam logic [7:0]  FUNC_WRITE_COIL = 8'd5;
  localparam logic [7:0]  FUNC_WRITE_REG  = 8'd6;

  localparam logic [15:0] COIL_ON   = 16'hFF00;
  localparam logic [15:0] COIL_OFF  = 16'h0000;
  localparam logic [15:0] CRC_INIT  = 16'hFFFF;
  localparam logic [15:0] CRC_POLY  = 16'hA001;

  localparam int PcW = 5;

  // program entry points and loop heads
  localparam logic [PcW-1:0] PC_RD_COILS  = 5'd0;
  localparam logic [PcW-1:0] PC_COIL_LOOP = 5'd3;
  localparam logic [PcW-1:0] PC_RD_REGS   = 5'd8;
  localparam logic [PcW-1:0] PC_REG_LOOP  = 5'd11;
  localparam logic [PcW-1:0] PC_WR_COIL   = 5'd16;
  localparam logic [PcW-1:0] PC_ECHO_BODY = 5'd17;
  localparam logic [PcW-1:0] PC_WR_REG    = 5'd24;

  typedef enum logic [3:0] {
    SRC_UNIT    = 4'd0,
    SRC_FUNC    = 4'd1,
    SRC_BC_COIL = 4'd2,
    SRC_BC_REG  = 4'd3,
    SRC_ADDR_HI = 4'd4,
    SRC_ADDR_LO = 4'd5,
    SRC_CV_HI   = 4'd6,
    SRC_CV_LO   = 4'd7,
    SRC_REG_HI  = 4'd8,
    SRC_REG_LO  = 4'd9,
    SRC_ACC     = 4'd10,
    SRC_CRC_LO  = 4'd11,
    SRC_CRC_HI  = 4'd12
  } src_e;

  typedef enum logic [2:0] {
    COND_NEXT     = 3'd0,
    COND_ALWAYS   = 3'd1,
    COND_BIT_MORE = 3'd2,
    COND_CNT_NZ   = 3'd3,
    COND_REG_MORE = 3'd4
  } cond_e;

  typedef struct packed {
    logic           emit;
    src_e           src;
    logic           last;
    logic           done;
    logic           clr_acc;
    logic           coil_shift;
    logic           reg_adv;
    logic           coil_wr;
    logic           reg_wr;
    cond_e          cond;
    logic [PcW-1:0] target;
  } uword_t;

  typedef struct packed {
    logic        coil_we;
    logic        coil_wd;
    logic        reg_we;
    logic [15:0] reg_wd;
  } wr_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  function automatic uword_t em(input src_e s);
    uword_t w;
    w      = '0;
    w.emit = 1'b1;
    w.src  = s;
    return w;
  endfunction

  function automatic uword_t ucode(input logic [PcW-1:0] pc);
    uword_t w;
    w = '0;
    unique case (pc)
      // read coils
      5'd0:  w = em(SRC_UNIT);
      5'd1:  w = em(SRC_FUNC);
      5'd2:  begin
        w = em(SRC_BC_COIL);
        w.clr_acc = 1'b1;
      end
      5'd3:  w = '0;
      5'd4:  begin
        w.coil_shift = 1'b1;
        w.cond       = COND_BIT_MORE;
        w.target     = PC_COIL_LOOP;
      end
      5'd5:  begin
        w = em(SRC_ACC);
        w.clr_acc = 1'b1;
        w.cond    = COND_CNT_NZ;
        w.target  = PC_COIL_LOOP;
      end
      5'd6:  w = em(SRC_CRC_LO);
      5'd7:  begin
        w = em(SRC_CRC_HI);
        w.last = 1'b1;
        w.done = 1'b1;
      end
      // read holding registers
      5'd8:  w = em(SRC_UNIT);
      5'd9:  w = em(SRC_FUNC);
      5'd10: w = em(SRC_BC_REG);
      5'd11: w = '0;
      5'd12: w = em(SRC_REG_HI);
      5'd13: begin
        w = em(SRC_REG_LO);
        w.reg_adv = 1'b1;
        w.cond    = COND_REG_MORE;
        w.target  = PC_REG_LOOP;
      end
      5'd14: w = em(SRC_CRC_LO);
      5'd15: begin
        w = em(SRC_CRC_HI);
        w.last = 1'b1;
        w.done = 1'b1;
      end
      // write coil, then shared echo
      5'd16: begin
        w = em(SRC_UNIT);
        w.coil_wr = 1'b1;
      end
      5'd17: w = em(SRC_FUNC);
      5'd18: w = em(SRC_ADDR_HI);
      5'd19: w = em(SRC_ADDR_LO);
      5'd20: w = em(SRC_CV_HI);
      5'd21: w = em(SRC_CV_LO);
      5'd22: w = em(SRC_CRC_LO);
      5'd23: begin
        w = em(SRC_CRC_HI);
        w.last = 1'b1;
        w.done = 1'b1;
      end
      // write register, then join the echo
      5'd24: begin
        w = em(SRC_UNIT);
        w.reg_wr = 1'b1;
        w.cond   = COND_ALWAYS;
        w.target = PC_ECHO_BODY;
      end
      default: begin
        w.done = 1'b1;
      end
    endcase
    return w;
  endfunction

endpackage

### src/mrs_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modbus RTU slave responder channels
// Request channel (decoded request) and response channel (frame bytes).
// ----------------------------------------------------------------------------
interface mrs_req_if;
  logic        valid;
  logic        ready;
  logic [7:0]  unit_id;
  logic [7:0]  function_code;
  logic [15:0] start_address;
  logic [15:0] count_or_value;

  modport source (output valid, unit_id, function_code, start_address, count_or_value,
                  input ready);
  modport sink   (input valid, unit_id, function_code, start_address, count_or_value,
                  output ready);
endinterface

interface mrs_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       last_byte;

  modport source (output valid, frame_byte, last_byte, input ready);
  modport sink   (input valid, frame_byte, last_byte, output ready);
endinterface

### src/modbus_rtu_slave_responder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modbus RTU slave responder
// Microcoded sequencer answering read/write coil and holding register requests.
// ----------------------------------------------------------------------------
// The entry word of the registered request emits the first response byte.
// Throughput: one frame byte per cycle while the response channel accepts, plus
//   wait words for each register and coil read (registered memory read port).
// Next request is taken once the last byte sits in the output register.
// Reset: a fill pass over max(NUM_COILS, NUM_REGS) entries loads the reset
//   image; no request is taken until it ends.
module modbus_rtu_slave_responder #(
  parameter int NUM_COILS = mrs_pkg::NumCoilsDef,
  parameter int NUM_REGS  = mrs_pkg::NumRegsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  mrs_req_if.sink   req_i,
  mrs_rsp_if.source rsp_o
);

  localparam int CoilW = (NUM_COILS > 1) ? $clog2(NUM_COILS) : 1;
  localparam int RegW  = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam int IdxW  = (CoilW > RegW) ? CoilW : RegW;
  localparam int NMax  = (NUM_COILS > NUM_REGS) ? NUM_COILS : NUM_REGS;
  localparam int CntW  = $clog2(NMax + 1);

  logic                     busy_q, busy_d;
  logic [mrs_pkg::PcW-1:0]  pc_q, pc_d;
  logic [7:0]               unit_q, unit_d;
  logic [7:0]               func_q, func_d;
  logic [15:0]              addr_q, addr_d;
  logic [15:0]              cv_q, cv_d;
  logic [IdxW-1:0]          idx_q, idx_d;
  logic [CntW-1:0]          cnt_q, cnt_d;
  logic [2:0]               pos_q, pos_d;
  logic [7:0]               acc_q, acc_d;
  logic [15:0]              crc_q, crc_d;
  logic                     out_valid_q, out_valid_d;
  logic [7:0]               out_byte_q, out_byte_d;
  logic                     out_last_q, out_last_d;

  mrs_pkg::uword_t          uw;
  mrs_pkg::wr_t             wr;
  logic                     init_busy;
  logic                     coil_rd;
  logic [15:0]              reg_rd;
  logic                     accept;
  logic                     out_free;
  logic                     step_go;
  logic                     take;
  logic                     req_ok;
  logic [mrs_pkg::PcW-1:0]  entry;
  logic [16:0]              span;
  logic [16:0]              bc_coil;
  logic [7:0]               byte_sel;

  mrs_store #(
    .NUM_COILS (NUM_COILS),
    .NUM_REGS  (NUM_REGS),
    .IdxW      (IdxW)
  ) u_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_addr_i   (idx_q),
    .wr_addr_i   (IdxW'(addr_q)),
    .wr_i        (wr),
    .init_busy_o (init_busy),
    .coil_rd_o   (coil_rd),
    .reg_rd_o    (reg_rd)
  );

  assign req_i.ready = !busy_q && !init_busy;
  assign accept      = req_i.valid && req_i.ready;

  // decode the request and pick the program entry
  always_comb begin
    span   = {1'b0, req_i.start_address} + {1'b0, req_i.count_or_value};
    req_ok = 1'b0;
    entry  = mrs_pkg::PC_RD_COILS;
    unique case (req_i.function_code)
      mrs_pkg::FUNC_READ_COILS: begin
        req_ok = (req_i.count_or_value != 16'd0) && (span <= 17'(NUM_COILS));
        entry  = mrs_pkg::PC_RD_COILS;
      end
      mrs_pkg::FUNC_READ_REGS: begin
        req_ok = (req_i.count_or_value != 16'd0) && (span <= 17'(NUM_REGS));
        entry  = mrs_pkg::PC_RD_REGS;
      end
      mrs_pkg::FUNC_WRITE_COIL: begin
        req_ok = req_i.start_address < 16'(NUM_COILS);
        entry  = mrs_pkg::PC_WR_COIL;
      end
      mrs_pkg::FUNC_WRITE_REG: begin
        req_ok = req_i.start_address < 16'(NUM_REGS);
        entry  = mrs_pkg::PC_WR_REG;
      end
      default: begin
        req_ok = 1'b0;
      end
    endcase
  end

  assign uw       = mrs_pkg::ucode(pc_q);
  assign out_free = !out_valid_q || rsp_o.ready;
  assign step_go  = busy_q && (!uw.emit || out_free);
  assign bc_coil  = ({1'b0, cv_q} + 17'd7) >> 3;

  always_comb begin
    unique case (uw.cond)
      mrs_pkg::COND_NEXT:     take = 1'b0;
      mrs_pkg::COND_ALWAYS:   take = 1'b1;
      mrs_pkg::COND_BIT_MORE: take = !((pos_q == 3'd7) || (cnt_q == CntW'(1)));
      mrs_pkg::COND_CNT_NZ:   take = cnt_q != '0;
      mrs_pkg::COND_REG_MORE: take = cnt_q != CntW'(1);
      default:                take = 1'b0;
    endcase
  end

  always_comb begin
    unique case (uw.src)
      mrs_pkg::SRC_UNIT:    byte_sel = unit_q;
      mrs_pkg::SRC_FUNC:    byte_sel = func_q;
      mrs_pkg::SRC_BC_COIL: byte_sel = bc_coil[7:0];
      mrs_pkg::SRC_BC_REG:  byte_sel = {cv_q[6:0], 1'b0};
      mrs_pkg::SRC_ADDR_HI: byte_sel = addr_q[15:8];
      mrs_pkg::SRC_ADDR_LO: byte_sel = addr_q[7:0];
      mrs_pkg::SRC_CV_HI:   byte_sel = cv_q[15:8];
      mrs_pkg::SRC_CV_LO:   byte_sel = cv_q[7:0];
      mrs_pkg::SRC_REG_HI:  byte_sel = reg_rd[15:8];
      mrs_pkg::SRC_REG_LO:  byte_sel = reg_rd[7:0];
      mrs_pkg::SRC_ACC:     byte_sel = acc_q;
      mrs_pkg::SRC_CRC_LO:  byte_sel = crc_q[7:0];
      mrs_pkg::SRC_CRC_HI:  byte_sel = crc_q[15:8];
      default:              byte_sel = 8'h00;
    endcase
  end

  always_comb begin
    wr.coil_we = step_go && uw.coil_wr
                 && ((cv_q == mrs_pkg::COIL_ON) || (cv_q == mrs_pkg::COIL_OFF));
    wr.coil_wd = cv_q == mrs_pkg::COIL_ON;
    wr.reg_we  = step_go && uw.reg_wr;
    wr.reg_wd  = cv_q;
  end

  always_comb begin
    busy_d      = busy_q;
    pc_d        = pc_q;
    unit_d      = unit_q;
    func_d      = func_q;
    addr_d      = addr_q;
    cv_d        = cv_q;
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    pos_d       = pos_q;
    acc_d       = acc_q;
    crc_d       = crc_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;

    if (accept) begin
      busy_d = req_ok;
      pc_d   = entry;
      unit_d = req_i.unit_id;
      func_d = req_i.function_code;
      addr_d = req_i.start_address;
      cv_d   = req_i.count_or_value;
      idx_d  = IdxW'(req_i.start_address);
      cnt_d  = CntW'(req_i.count_or_value);
      pos_d  = 3'd0;
      acc_d  = 8'h00;
      crc_d  = mrs_pkg::CRC_INIT;
    end else if (step_go) begin
      if (uw.done) begin
        busy_d = 1'b0;
      end else if (take) begin
        pc_d = uw.target;
      end else begin
        pc_d = pc_q + mrs_pkg::PcW'(1);
      end
      if (uw.emit) begin
        out_valid_d = 1'b1;
        out_byte_d  = byte_sel;
        out_last_d  = uw.last;
        if ((uw.src != mrs_pkg::SRC_CRC_LO) && (uw.src != mrs_pkg::SRC_CRC_HI)) begin
          crc_d = mrs_pkg::crc_byte(crc_q, byte_sel);
        end
      end
      if (uw.coil_shift) begin
        acc_d = acc_q | (8'(coil_rd) << pos_q);
        pos_d = pos_q + 3'd1;
        idx_d = idx_q + IdxW'(1);
        cnt_d = cnt_q - CntW'(1);
      end
      if (uw.reg_adv) begin
        idx_d = idx_q + IdxW'(1);
        cnt_d = cnt_q - CntW'(1);
      end
      if (uw.clr_acc) begin
        acc_d = 8'h00;
        pos_d = 3'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      pc_q        <= mrs_pkg::PC_RD_COILS;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      pc_q        <= pc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unit_q     <= unit_d;
    func_q     <= func_d;
    addr_q     <= addr_d;
    cv_q       <= cv_d;
    idx_q      <= idx_d;
    cnt_q      <= cnt_d;
    pos_q      <= pos_d;
    acc_q      <= acc_d;
    crc_q      <= crc_d;
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.frame_byte = out_byte_q;
  assign rsp_o.last_byte  = out_last_q;

endmodule

### src/mrs_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Coil and holding register store
// Two dual-port memories with registered reads and a post-reset fill pass.
// ----------------------------------------------------------------------------
module mrs_store #(
  parameter int NUM_COILS = mrs_pkg::NumCoilsDef,
  parameter int NUM_REGS  = mrs_pkg::NumRegsDef,
  parameter int IdxW      = (NUM_COILS > NUM_REGS)
                            ? ((NUM_COILS > 1) ? $clog2(NUM_COILS) : 1)
                            : ((NUM_REGS > 1) ? $clog2(NUM_REGS) : 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [IdxW-1:0]    rd_addr_i,
  input  logic [IdxW-1:0]    wr_addr_i,
  input  mrs_pkg::wr_t       wr_i,
  output logic               init_busy_o,
  output logic               coil_rd_o,
  output logic [15:0]        reg_rd_o
);

  localparam int CoilW = (NUM_COILS > 1) ? $clog2(NUM_COILS) : 1;
  localparam int RegW  = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam int NMax  = (NUM_COILS > NUM_REGS) ? NUM_COILS : NUM_REGS;

  logic              coil_mem [NUM_COILS];
  logic [15:0]       reg_mem  [NUM_REGS];

  logic              init_q, init_d;
  logic [IdxW-1:0]   init_idx_q, init_idx_d;

  always_comb begin
    init_d     = init_q;
    init_idx_d = init_idx_q;
    if (init_q) begin
      if (int'(init_idx_q) == NMax - 1) begin
        init_d = 1'b0;
      end else begin
        init_idx_d = init_idx_q + IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q     <= 1'b1;
      init_idx_q <= '0;
    end else begin
      init_q     <= init_d;
      init_idx_q <= init_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (init_q) begin
      if (int'(init_idx_q) < NUM_COILS) begin
        coil_mem[init_idx_q[CoilW-1:0]] <= (int'(init_idx_q) < 8);
      end
    end else if (wr_i.coil_we) begin
      coil_mem[wr_addr_i[CoilW-1:0]] <= wr_i.coil_wd;
    end
    coil_rd_o <= coil_mem[rd_addr_i[CoilW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (init_q) begin
      if (int'(init_idx_q) < NUM_REGS) begin
        reg_mem[init_idx_q[RegW-1:0]] <= 16'(int'(init_idx_q) * 2 + 3);
      end
    end else if (wr_i.reg_we) begin
      reg_mem[wr_addr_i[RegW-1:0]] <= wr_i.reg_wd;
    end
    reg_rd_o <= reg_mem[rd_addr_i[RegW-1:0]];
  end

  assign init_busy_o = init_q;

endmodule

### verif/tb_modbus_rtu_slave_responder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modbus RTU slave responder testbench
// Sends decoded requests through the request channel and checks every frame
// byte against a scoreboard built by a local model of the coil and register
// maps and the CRC-16 trailer. Directed edge cases come first, then random
// traffic with bursty requests and a throttled response channel.
// ----------------------------------------------------------------------------
module tb_modbus_rtu_slave_responder;
  import mrs_pkg::*;

  localparam int COIL_COUNT = NumCoilsDef;
  localparam int REG_COUNT  = NumRegsDef;
  localparam int SETTLE     = 48;
  localparam int LIMIT      = 400000;

  localparam logic [7:0] FUNC_NONE       = 8'h00;
  localparam logic [7:0] FUNC_READ_INPUT = 8'h02;
  localparam logic [7:0] FUNC_READ_INREG = 8'h04;
  localparam logic [7:0] FUNC_ALL_ONES   = 8'hFF;

  typedef struct packed {
    logic [7:0]  unit;
    logic [7:0]  func;
    logic [15:0] addr;
    logic [15:0] cv;
  } request_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } frame_byte_t;

  typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PERIODIC, STALL_HEAVY} stall_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  mrs_req_if req_bus ();
  mrs_rsp_if rsp_bus ();

  modbus_rtu_slave_responder uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus)
  );

  always #2 clk_i = ~clk_i;

  bit          coil_state [COIL_COUNT];
  logic [15:0] reg_state  [REG_COUNT];
  frame_byte_t frame_q [$];
  frame_byte_t next_byte;
  int          fail_count;
  int          cycle_count;
  int          burst_left;
  stall_e      stall_mode;

  function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      if (c[0] ^ data[i]) begin
        c = {1'b0, c[15:1]} ^ CRC_POLY;
      end else begin
        c = {1'b0, c[15:1]};
      end
    end
    return c;
  endfunction

  function automatic void reset_maps();
    for (int i = 0; i < COIL_COUNT; i++) begin
      coil_state[i] = (i < 8);
    end
    for (int i = 0; i < REG_COUNT; i++) begin
      reg_state[i] = 16'(2 * i + 3);
    end
  endfunction

  function automatic void predict_frame(input request_t r);
    logic [7:0]  body [$];
    logic [15:0] crc;
    logic [7:0]  acc;
    int unsigned a;
    int unsigned n;
    int          pos;
    bit          answered;
    a        = r.addr;
    n        = r.cv;
    answered = 1'b0;
    body     = {r.unit, r.func};
    case (r.func)
      FUNC_READ_COILS: begin
        if (n != 0 && a + n <= COIL_COUNT) begin
          answered = 1'b1;
          body = {body, 8'((n + 7) / 8)};
          acc = '0;
          pos = 0;
          for (int i = 0; i < n; i++) begin
            if (coil_state[a + i]) acc[pos] = 1'b1;
            pos++;
            if (pos == 8) begin
              body = {body, acc};
              acc = '0;
              pos = 0;
            end
          end
          if (pos != 0) body = {body, acc};
        end
      end
      FUNC_READ_REGS: begin
        if (n != 0 && a + n <= REG_COUNT) begin
          answered = 1'b1;
          body = {body, 8'(2 * n)};
          for (int i = 0; i < n; i++) begin
            body = {body, reg_state[a + i][15:8], reg_state[a + i][7:0]};
          end
        end
      end
      FUNC_WRITE_COIL, FUNC_WRITE_REG: begin
        if (r.func == FUNC_WRITE_COIL && a < COIL_COUNT) begin
          answered = 1'b1;
          if (r.cv == COIL_ON) begin
            coil_state[a] = 1'b1;
          end else if (r.cv == COIL_OFF) begin
            coil_state[a] = 1'b0;
          end
        end else if (r.func == FUNC_WRITE_REG && a < REG_COUNT) begin
          answered     = 1'b1;
          reg_state[a] = r.cv;
        end
        body = {body, r.addr[15:8], r.addr[7:0], r.cv[15:8], r.cv[7:0]};
      end
      default: ;
    endcase
    if (!answered) return;
    crc = CRC_INIT;
    foreach (body[i]) crc = crc16_update(crc, body[i]);
    body = {body, crc[7:0], crc[15:8]};
    foreach (body[i]) begin
      frame_q = {frame_q, frame_byte_t'({body[i], i == body.size() - 1})};
    end
  endfunction

  // predict on each accepted request, then check each accepted frame byte
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_bus.valid && req_bus.ready) begin
        predict_frame(request_t'({req_bus.unit_id, req_bus.function_code,
                                  req_bus.start_address, req_bus.count_or_value}));
      end
      if (rsp_bus.valid && rsp_bus.ready) begin
        if (frame_q.size() == 0) begin
          $display("%0t: unexpected frame byte, expected none, actual %02h last %0b",
                   $time, rsp_bus.frame_byte, rsp_bus.last_byte);
          fail_count++;
        end else begin
          next_byte = frame_q.pop_front();
          if (rsp_bus.frame_byte !== next_byte.data) begin
            $display("%0t: frame_byte mismatch, expected %02h actual %02h",
                     $time, next_byte.data, rsp_bus.frame_byte);
            fail_count++;
          end
          if (rsp_bus.last_byte !== next_byte.last) begin
            $display("%0t: last_byte mismatch, expected %0b actual %0b",
                     $time, next_byte.last, rsp_bus.last_byte);
            fail_count++;
          end
        end
      end
    end
  end

  // throttle the response channel
  always @(posedge clk_i) begin
    if (cycle_count % 97 == 0) stall_mode = stall_e'($urandom_range(0, 3));
    case (stall_mode)
      STALL_NONE:     rsp_bus.ready <= 1'b1;
      STALL_RANDOM:   rsp_bus.ready <= 1'($urandom_range(0, 1));
      STALL_PERIODIC: rsp_bus.ready <= (cycle_count % 3 == 0);
      default:        rsp_bus.ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic send_request(input logic [7:0] unit, input logic [7:0] func,
                              input logic [15:0] addr, input logic [15:0] cv);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
      gap        = $urandom_range(0, 6);
      if (gap != 0) begin
        req_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    req_bus.valid          <= 1'b1;
    req_bus.unit_id        <= unit;
    req_bus.function_code  <= func;
    req_bus.start_address  <= addr;
    req_bus.count_or_value <= cv;
    do @(posedge clk_i); while (!req_bus.ready);
  endtask

  // hold requests until every expected byte is out
  task automatic drain();
    req_bus.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (frame_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic test_read_coils();
    send_request(8'h01, FUNC_READ_COILS, 16'd0, 16'd16);
    send_request(8'hFF, FUNC_READ_COILS, 16'd15, 16'd1);
    send_request(8'h00, FUNC_READ_COILS, 16'd3, 16'd9);
    send_request(8'h11, FUNC_READ_COILS, 16'd2, 16'd0);
    send_request(8'h12, FUNC_READ_COILS, 16'd10, 16'd7);
    send_request(8'h13, FUNC_READ_COILS, 16'hFFFF, 16'hFFFF);
    drain();
  endtask

  task automatic test_read_regs();
    send_request(8'h21, FUNC_READ_REGS, 16'd0, 16'd16);
    send_request(8'h22, FUNC_READ_REGS, 16'd15, 16'd1);
    send_request(8'h23, FUNC_READ_REGS, 16'd4, 16'd0);
    send_request(8'h24, FUNC_READ_REGS, 16'd15, 16'd2);
    send_request(8'h25, FUNC_READ_REGS, 16'd0, 16'hFFFF);
    drain();
  endtask

  task automatic test_write_coil();
    send_request(8'h31, FUNC_WRITE_COIL, 16'd8, COIL_ON);
    send_request(8'h32, FUNC_WRITE_COIL, 16'd0, COIL_OFF);
    send_request(8'h33, FUNC_WRITE_COIL, 16'd3, 16'h1234);
    send_request(8'h34, FUNC_WRITE_COIL, 16'd16, COIL_ON);
    send_request(8'h35, FUNC_WRITE_COIL, 16'hFFFF, COIL_OFF);
    send_request(8'h36, FUNC_READ_COILS, 16'd0, 16'd16);
    drain();
  endtask

  task automatic test_write_reg();
    send_request(8'h41, FUNC_WRITE_REG, 16'd0, 16'hFFFF);
    send_request(8'h42, FUNC_WRITE_REG, 16'd15, 16'h0000);
    send_request(8'h43, FUNC_WRITE_REG, 16'd16, 16'hA5A5);
    send_request(8'h44, FUNC_READ_REGS, 16'd0, 16'd16);
    drain();
  endtask

  task automatic test_unsupported();
    send_request(8'h00, FUNC_NONE, 16'd0, 16'd1);
    send_request(8'hFF, FUNC_READ_INPUT, 16'd0, 16'd8);
    send_request(8'h5A, FUNC_READ_INREG, 16'd0, 16'd4);
    send_request(8'hA5, FUNC_ALL_ONES, 16'hFFFF, 16'hFFFF);
    drain();
  endtask

  task automatic test_random_traffic(input int target);
    int          answered;
    int          pick;
    logic [7:0]  func;
    logic [15:0] addr;
    logic [15:0] cv;
    bit          broken;
    answered = 0;
    while (answered < target) begin
      pick   = $urandom_range(0, 99);
      broken = ($urandom_range(0, 9) == 0);
      if (pick < 25) begin
        func = FUNC_READ_COILS;
        addr = 16'($urandom_range(0, COIL_COUNT - 1));
        cv   = 16'($urandom_range(1, COIL_COUNT - addr));
        if (broken) cv = ($urandom_range(0, 1) != 0) ? 16'd0 : 16'(COIL_COUNT - addr + 1);
      end else if (pick < 50) begin
        func = FUNC_READ_REGS;
        addr = 16'($urandom_range(0, REG_COUNT - 1));
        cv   = 16'($urandom_range(1, REG_COUNT - addr));
        if (broken) cv = ($urandom_range(0, 1) != 0) ? 16'd0 : 16'(REG_COUNT - addr + 1);
      end else if (pick < 70) begin
        func = FUNC_WRITE_COIL;
        addr = 16'($urandom_range(0, COIL_COUNT - 1));
        case ($urandom_range(0, 4))
          0, 1:    cv = COIL_ON;
          2, 3:    cv = COIL_OFF;
          default: cv = 16'($urandom);
        endcase
        if (broken) addr = 16'($urandom_range(COIL_COUNT, 16'hFFFF));
      end else if (pick < 88) begin
        func = FUNC_WRITE_REG;
        addr = 16'($urandom_range(0, REG_COUNT - 1));
        cv   = 16'($urandom);
        if (broken) addr = 16'($urandom_range(REG_COUNT, 16'hFFFF));
      end else begin
        func   = 8'($urandom_range(0, 255));
        addr   = 16'($urandom);
        cv     = 16'($urandom);
        broken = 1'b1;
      end
      send_request(8'($urandom_range(0, 255)), func, addr, cv);
      if (!broken) begin
        answered++;
        if (answered % 40 == 0) drain();
      end
    end
    drain();
  endtask

  initial begin
    rst_ni                 = 1'b0;
    req_bus.valid          = 1'b0;
    req_bus.unit_id        = '0;
    req_bus.function_code  = '0;
    req_bus.start_address  = '0;
    req_bus.count_or_value = '0;
    burst_left             = 0;
    reset_maps();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_read_coils();
    test_read_regs();
    test_write_coil();
    test_write_reg();
    test_unsupported();
    test_random_traffic(80);
    if (fail_count == 0 && frame_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
